// ===== sv/cdt_pkg.sv =====
// Package for the countdown timer with hex display.
// Holds payload structs, operation codes, digit state type and segment/decimal helpers.
// No dependencies.
package cdt_pkg;

	// Operation codes carried in the input item
	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_TOGGLE  = 3'd1,
		OP_SET_HUN = 3'd2,
		OP_SET_SEC = 3'd3,
		OP_SET_MIN = 3'd4
	} op_t;

	localparam int unsigned SW_W    = 10;
	localparam int unsigned HUN_MAX = 99;
	localparam int unsigned SEC_MAX = 59;
	localparam int unsigned MIN_MAX = 59;

	// Top values the digits wrap to on underflow
	localparam logic [3:0] DEC_TOP = 4'd9;
	localparam logic [2:0] SEX_TOP = 3'd5;

	typedef struct packed {
		logic [2:0]      operation;
		logic [SW_W-1:0] switches;
	} in_t;

	typedef struct packed {
		logic [30:0] hex_low_word;
		logic [14:0] hex_high_word;
		logic        running;
	} out_t;

	// Digit state plus run flag
	typedef struct packed {
		logic [3:0] hun_ones;
		logic [3:0] hun_tens;
		logic [3:0] sec_ones;
		logic [2:0] sec_tens;
		logic [3:0] min_ones;
		logic [2:0] min_tens;
		logic       run;
	} timer_t;

	// Tens and ones of a two-digit value
	typedef struct packed {
		logic [3:0] tens;
		logic [3:0] ones;
	} bcd2_t;

	// Seven-segment pattern, bit 0 = segment a; blank for non-decimal codes
	function automatic logic [7:0] seg_of(input logic [3:0] digit);
		logic [7:0] pat;
		unique case (digit)
			4'd0:    pat = 8'h3F;
			4'd1:    pat = 8'h06;
			4'd2:    pat = 8'h5B;
			4'd3:    pat = 8'h4F;
			4'd4:    pat = 8'h66;
			4'd5:    pat = 8'h6D;
			4'd6:    pat = 8'h7D;
			4'd7:    pat = 8'h07;
			4'd8:    pat = 8'h7F;
			4'd9:    pat = 8'h6F;
			default: pat = 8'h00;
		endcase
		return pat;
	endfunction

	// Split 0..99 into tens and ones: tens = (x * 205) >> 11, exact below 1029
	function automatic bcd2_t split_bcd(input logic [6:0] x);
		logic [14:0] prod;
		logic [3:0]  tens;
		logic [6:0]  rem;
		prod = 15'(x) * 15'd205;
		tens = prod[14:11];
		rem  = x - 7'(tens) * 7'd10;
		return '{tens: tens, ones: rem[3:0]};
	endfunction

endpackage

// ===== sv/countdown_timer_hex_display.sv =====
// Countdown timer with six-digit seven-segment display, top level.
// Throughput: one item per cycle unless out_ready low stalls the result register.
// The digit update and segment encode take one stage, between input and result registers.
// Reset (arst_n low): both pipeline stages empty, display state 59:59.99, running.
// Depends on cdt_pkg and cdt_digits.
module countdown_timer_hex_display (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cdt_pkg::in_t  in_item,
	output logic          out_valid,
	input  logic          out_ready,
	output cdt_pkg::out_t out_item
);
	import cdt_pkg::*;

	logic       valid_s1;
	in_t        item_s1;
	logic       valid_s2;
	out_t       res_s2;
	logic       adv_s1;
	timer_t     nxt;
	logic [6:0] seg_sec_tens;
	logic [6:0] seg_min_tens;

	// Stage 1 moves on when the result register is free or being drained
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_s1 <= in_item;
	end

	cdt_digits u_digits (
		.clk   (clk),
		.arst_n(arst_n),
		.upd   (adv_s1),
		.item  (item_s1),
		.nxt   (nxt)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Tens digits fill only the low seven bits of their top byte
	assign seg_sec_tens = 7'(seg_of({1'b0, nxt.sec_tens}));
	assign seg_min_tens = 7'(seg_of({1'b0, nxt.min_tens}));

	// Segment encode of the updated digits
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2.hex_low_word  <= {seg_sec_tens, seg_of(nxt.sec_ones),
			                         seg_of(nxt.hun_tens), seg_of(nxt.hun_ones)};
			res_s2.hex_high_word <= {seg_min_tens, seg_of(nxt.min_ones)};
			res_s2.running       <= nxt.run;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = res_s2;

endmodule

// ===== sv/cdt_digits.sv =====
// Digit state of the countdown timer: six cascaded decimal digits and run flag.
// Applies one operation per update and presents the resulting state.
// Depends on cdt_pkg.
module cdt_digits (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           upd,
	input  cdt_pkg::in_t   item,
	output cdt_pkg::timer_t nxt
);
	import cdt_pkg::*;

	timer_t cur_q;
	bcd2_t  sw_bcd;
	logic   b0, b1, b2, b3, b4;
	timer_t dec;

	assign sw_bcd = split_bcd(item.switches[6:0]);

	// Borrow chain for one hundredth down, wrapping at zero
	always_comb begin
		dec = cur_q;
		b0  = (cur_q.hun_ones == '0);
		b1  = b0 && (cur_q.hun_tens == '0);
		b2  = b1 && (cur_q.sec_ones == '0);
		b3  = b2 && (cur_q.sec_tens == '0);
		b4  = b3 && (cur_q.min_ones == '0);
		dec.hun_ones = b0 ? DEC_TOP : cur_q.hun_ones - 4'd1;
		if (b0) begin
			dec.hun_tens = b1 ? DEC_TOP : cur_q.hun_tens - 4'd1;
		end
		if (b1) begin
			dec.sec_ones = b2 ? DEC_TOP : cur_q.sec_ones - 4'd1;
		end
		if (b2) begin
			dec.sec_tens = b3 ? SEX_TOP : cur_q.sec_tens - 3'd1;
		end
		if (b3) begin
			dec.min_ones = b4 ? DEC_TOP : cur_q.min_ones - 4'd1;
		end
		if (b4) begin
			dec.min_tens = (cur_q.min_tens == '0) ? SEX_TOP : cur_q.min_tens - 3'd1;
		end
	end

	// Next state for the operation in hand
	always_comb begin
		nxt = cur_q;
		unique case (item.operation)
			OP_TICK: begin
				if (cur_q.run) nxt = dec;
			end
			OP_TOGGLE: begin
				nxt.run = ~cur_q.run;
			end
			OP_SET_HUN: begin
				if (item.switches <= SW_W'(HUN_MAX)) begin
					nxt.hun_ones = sw_bcd.ones;
					nxt.hun_tens = sw_bcd.tens;
				end
			end
			OP_SET_SEC: begin
				if (item.switches <= SW_W'(SEC_MAX)) begin
					nxt.sec_ones = sw_bcd.ones;
					nxt.sec_tens = sw_bcd.tens[2:0];
				end
			end
			OP_SET_MIN: begin
				if (item.switches <= SW_W'(MIN_MAX)) begin
					nxt.min_ones = sw_bcd.ones;
					nxt.min_tens = sw_bcd.tens[2:0];
				end
			end
			default: begin
			end
		endcase
	end

	// State register, reset to 59:59.99 running
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '{hun_ones: DEC_TOP, hun_tens: DEC_TOP, sec_ones: DEC_TOP,
			           sec_tens: SEX_TOP, min_ones: DEC_TOP, min_tens: SEX_TOP,
			           run: 1'b1};
		end else if (upd) begin
			cur_q <= nxt;
		end
	end

endmodule
